### hw/rtl/pwl_pkg.sv
// ----------------------------------------------------------------------------
// pwl_pkg
// Shared sizes, codes and stage records of the piecewise-linear decompander.
// ----------------------------------------------------------------------------
package pwl_pkg;

    // Table depth and pixel width.
    localparam int MAX_KNEES  = 16;
    localparam int PIXEL_BITS = 16;

    // Field widths fixed by the interface.
    localparam int IDX_IN_W   = 4;
    localparam int CNT_CFG_W  = 5;
    localparam int Y_W        = 31;
    localparam int SLOPE_W    = 16;

    // Derived widths.
    localparam int KIDX_W     = (MAX_KNEES > 1) ? $clog2(MAX_KNEES) : 1;
    localparam int KCNT_W     = $clog2(MAX_KNEES + 1);
    localparam int D_W        = PIXEL_BITS + 1;
    localparam int P_W        = D_W + SLOPE_W + 1;
    localparam int S_W        = ((P_W > Y_W + 1) ? P_W : Y_W + 1) + 1;

    // Operation carried by an input word.
    typedef enum logic {
        OP_EXPAND     = 1'b0,
        OP_KNEE_WRITE = 1'b1
    } t_op;

    // Input word as captured at the first stage.
    typedef struct packed {
        t_op                   op;
        logic [PIXEL_BITS-1:0] pixel;
        logic [IDX_IN_W-1:0]   kidx;
        logic [PIXEL_BITS-1:0] kx;
        logic [Y_W-1:0]        ky;
        logic [SLOPE_W-1:0]    kslope;
    } t_word;

    // Word after the segment search.
    typedef struct packed {
        t_word             w;
        logic [KIDX_W-1:0] k;
        logic              err;
    } t_seg;

    // One knee point as stored for the previous-knee lookup.
    typedef struct packed {
        logic [PIXEL_BITS-1:0] x;
        logic [Y_W-1:0]        y;
    } t_xy;

    // Pixel with its segment operands fetched.
    typedef struct packed {
        logic [PIXEL_BITS-1:0] pixel;
        t_xy                   prev;
        logic [SLOPE_W-1:0]    slope;
        logic                  err;
    } t_fetch;

    // Pixel after the slope multiply.
    typedef struct packed {
        logic signed [P_W-1:0] prod;
        logic [Y_W-1:0]        y;
        logic                  err;
    } t_prod;

endpackage

### hw/rtl/pwl_knee_search.sv
// ----------------------------------------------------------------------------
// pwl_knee_search
// Input stage and segment search: holds the knee x lanes and finds, for each
// pixel, the first knee past knee zero at or above it.
// ----------------------------------------------------------------------------
module pwl_knee_search
    import pwl_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [CNT_CFG_W-1:0] i_knee_count,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  t_word                i_word,
    output logic                 o_valid,
    input  logic                 i_ready,
    output t_seg                 o_seg
);

    logic                  r_v1;
    t_word                 r_s1;
    logic                  r_v2;
    t_seg                  r_s2;
    logic [PIXEL_BITS-1:0] r_knee_x [MAX_KNEES];

    logic                  s1_rdy;
    logic                  s2_rdy;
    logic [KCNT_W-1:0]     n_used;
    logic [KIDX_W-1:0]     n_k;
    logic                  n_err;
    logic                  lane_wr;

    assign s2_rdy  = !r_v2 || i_ready;
    assign s1_rdy  = !r_v1 || s2_rdy;
    assign o_ready = s1_rdy;
    assign o_valid = r_v2;
    assign o_seg   = r_s2;

    // Knee count in use, saturated to the table depth.
    always_comb begin
        if (32'(i_knee_count) > 32'(MAX_KNEES)) begin
            n_used = KCNT_W'(MAX_KNEES);
        end else begin
            n_used = KCNT_W'(i_knee_count);
        end
        n_err = (n_used < KCNT_W'(2));
    end

    // Parallel compares against every knee in use above knee zero; the lowest hit
    // wins, otherwise the last knee in use closes the curve.
    always_comb begin
        n_k = KIDX_W'(n_used - KCNT_W'(1));
        for (int i = MAX_KNEES - 1; i >= 1; i--) begin
            if ((KCNT_W'(i) < n_used) && (r_s1.pixel <= r_knee_x[i])) begin
                n_k = KIDX_W'(i);
            end
        end
    end

    // A knee write updates its x lane as it leaves the first stage, so the
    // pixels behind it compare against the new value.
    assign lane_wr = r_v1 && s2_rdy && (r_s1.op == OP_KNEE_WRITE)
                     && (32'(r_s1.kidx) < 32'(MAX_KNEES));

    // Stage valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (s1_rdy) begin
                r_v1 <= i_valid;
            end
            if (s2_rdy) begin
                r_v2 <= r_v1;
            end
        end
    end

    // Stage payloads and knee x lanes.
    always_ff @(posedge i_clk) begin
        if (i_valid && s1_rdy) begin
            r_s1 <= i_word;
        end
        if (r_v1 && s2_rdy) begin
            r_s2.w   <= r_s1;
            r_s2.k   <= n_k;
            r_s2.err <= n_err;
        end
        if (lane_wr) begin
            r_knee_x[KIDX_W'(r_s1.kidx)] <= r_s1.kx;
        end
    end

    // A pixel that passes the search with a valid curve never points at
    // knee zero, which has no previous knee.
    a_seg_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v2 && (r_s2.w.op == OP_EXPAND) && !r_s2.err) |-> (r_s2.k != '0))
        else $error("segment index zero on a valid curve");

    // Reset empties both stages.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (!r_v1 && !r_v2))
        else $error("search stages not empty after reset");

endmodule

### hw/rtl/pwl_knee_fetch.sv
// ----------------------------------------------------------------------------
// pwl_knee_fetch
// Knee tables: reads the previous knee (x, y) and the segment slope for each
// pixel and applies knee writes in stream order.
// ----------------------------------------------------------------------------
module pwl_knee_fetch
    import pwl_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    output logic   o_ready,
    input  t_seg   i_seg,
    output logic   o_valid,
    input  logic   i_ready,
    output t_fetch o_fetch
);

    t_xy                r_xy_mem    [MAX_KNEES];
    logic [SLOPE_W-1:0] r_slope_mem [MAX_KNEES];
    logic               r_v3;
    t_fetch             r_f;

    logic               s3_rdy;
    logic               adv;
    logic               mem_wr;
    logic [KIDX_W-1:0]  prev_addr;
    logic [KIDX_W-1:0]  wr_addr;

    assign s3_rdy    = !r_v3 || i_ready;
    assign o_ready   = s3_rdy;
    assign o_valid   = r_v3;
    assign o_fetch   = r_f;
    assign adv       = i_valid && s3_rdy;
    assign prev_addr = i_seg.k - KIDX_W'(1);
    assign wr_addr   = KIDX_W'(i_seg.w.kidx);
    assign mem_wr    = adv && (i_seg.w.op == OP_KNEE_WRITE)
                       && (32'(i_seg.w.kidx) < 32'(MAX_KNEES));

    // Only pixels go on; a knee write ends here.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (s3_rdy) begin
            r_v3 <= i_valid && (i_seg.w.op == OP_EXPAND);
        end
    end

    // Table writes and registered reads.
    always_ff @(posedge i_clk) begin
        if (mem_wr) begin
            r_xy_mem[wr_addr]    <= '{x: i_seg.w.kx, y: i_seg.w.ky};
            r_slope_mem[wr_addr] <= i_seg.w.kslope;
        end
        if (adv) begin
            r_f.prev  <= r_xy_mem[prev_addr];
            r_f.slope <= r_slope_mem[i_seg.k];
            r_f.pixel <= i_seg.w.pixel;
            r_f.err   <= i_seg.err;
        end
    end

endmodule

### hw/rtl/pwl_seg_eval.sv
// ----------------------------------------------------------------------------
// pwl_seg_eval
// Segment evaluation: multiplies the offset from the previous knee by the
// slope, adds the previous knee y and clips to [0, max_value].
// ----------------------------------------------------------------------------
module pwl_seg_eval
    import pwl_pkg::*;
(
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic [Y_W-1:0] i_max_value,
    input  logic           i_valid,
    output logic           o_ready,
    input  t_fetch         i_fetch,
    output logic           o_valid,
    input  logic           i_ready,
    output logic [Y_W-1:0] o_expanded,
    output logic           o_curve_error
);

    logic           r_v4;
    t_prod          r_p;
    logic           r_out_valid;
    logic [Y_W-1:0] r_expanded;
    logic           r_err;

    logic                  s4_rdy;
    logic                  s5_rdy;
    logic signed [D_W-1:0] n_diff;
    logic signed [P_W-1:0] n_prod;
    logic signed [S_W-1:0] n_sum;
    logic signed [S_W-1:0] max_s;
    logic [Y_W-1:0]        n_expanded;

    assign s5_rdy        = !r_out_valid || i_ready;
    assign s4_rdy        = !r_v4 || s5_rdy;
    assign o_ready       = s4_rdy;
    assign o_valid       = r_out_valid;
    assign o_expanded    = r_expanded;
    assign o_curve_error = r_err;

    // Signed offset from the previous knee, times the segment slope.
    always_comb begin
        n_diff = signed'({1'b0, i_fetch.pixel}) - signed'({1'b0, i_fetch.prev.x});
        n_prod = P_W'(n_diff) * P_W'(signed'({1'b0, i_fetch.slope}));
    end

    // Add the knee y at full width, then clip; a short curve gives zero.
    always_comb begin
        n_sum = S_W'(r_p.prod) + S_W'(signed'({1'b0, r_p.y}));
        max_s = signed'(S_W'(i_max_value));
        if (r_p.err || (n_sum < S_W'(0))) begin
            n_expanded = '0;
        end else if (n_sum > max_s) begin
            n_expanded = i_max_value;
        end else begin
            n_expanded = n_sum[Y_W-1:0];
        end
    end

    // Stage valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s4_rdy) begin
                r_v4 <= i_valid;
            end
            if (s5_rdy) begin
                r_out_valid <= r_v4;
            end
        end
    end

    // Product register and output register.
    always_ff @(posedge i_clk) begin
        if (i_valid && s4_rdy) begin
            r_p.prod <= n_prod;
            r_p.y    <= i_fetch.prev.y;
            r_p.err  <= i_fetch.err;
        end
        if (r_v4 && s5_rdy) begin
            r_expanded <= n_expanded;
            r_err      <= r_p.err;
        end
    end

    // A flagged curve always reports zero.
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_err) |-> (r_expanded == '0))
        else $error("curve error word with nonzero value");

    // A product held by a stall stays intact until it moves on.
    a_prod_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v4 && !s5_rdy) |=> (r_v4 && (r_p === $past(r_p))))
        else $error("product stage lost or changed under stall");

endmodule

### hw/rtl/pwl_decompand_unit.sv
// ----------------------------------------------------------------------------
// pwl_decompand_unit
// Piecewise-linear decompander: expands companded pixels through a loaded
// knee curve, with an APB-style port for the knee count and clip bound.
//
//   channel   direction  handshake                  payload
//   input     in         i_in_valid / o_in_ready    i_operation, i_pixel,
//                                                    i_knee_index, i_knee_x,
//                                                    i_knee_y, i_knee_slope
//   output    out        o_out_valid / i_out_ready  o_expanded, o_curve_error
//   config    in         psel/penable/pwrite/pready paddr, pwdata, prdata
//
// One word enters per clock while no stall holds the stages; a pixel result
// passes the input, search, table read, multiply and clip/output registers
// on its way out. Knee writes pass the input and search stages and
// end at the table stage, in stream order; they give no result.
// Each stage has its own valid bit and holds under a stall, so bubbles are
// squeezed out and the input keeps flowing while a result waits, until the
// stages are full.
// Reset is synchronous and active low; it empties the pipeline and loads the
// register defaults. The knee tables are not cleared.
// ----------------------------------------------------------------------------
module pwl_decompand_unit
    import pwl_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [2:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    // Input words
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic                  i_operation,
    input  logic [PIXEL_BITS-1:0] i_pixel,
    input  logic [IDX_IN_W-1:0]   i_knee_index,
    input  logic [PIXEL_BITS-1:0] i_knee_x,
    input  logic [Y_W-1:0]        i_knee_y,
    input  logic [SLOPE_W-1:0]    i_knee_slope,
    // Result words
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [Y_W-1:0]        o_expanded,
    output logic                  o_curve_error
);

    // Register selects, one per word address.
    localparam logic REG_KNEE_COUNT = 1'b0;
    localparam logic REG_MAX_VALUE  = 1'b1;

    logic [CNT_CFG_W-1:0] r_knee_count;
    logic [Y_W-1:0]       r_max_value;

    logic   cfg_wr;
    t_word  in_word;
    logic   seg_valid;
    logic   seg_ready;
    t_seg   seg;
    logic   fetch_valid;
    logic   fetch_ready;
    t_fetch fetch;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_knee_count <= '0;
            r_max_value  <= Y_W'(16777215);
        end else if (cfg_wr) begin
            unique case (paddr[2])
                REG_KNEE_COUNT: r_knee_count <= pwdata[CNT_CFG_W-1:0];
                REG_MAX_VALUE:  r_max_value  <= pwdata[Y_W-1:0];
                default:        ;
            endcase
        end
    end

    // Register readback.
    always_comb begin
        unique case (paddr[2])
            REG_KNEE_COUNT: prdata = 32'(r_knee_count);
            REG_MAX_VALUE:  prdata = 32'(r_max_value);
            default:        prdata = '0;
        endcase
    end

    // Gather the input word.
    always_comb begin
        in_word.op     = t_op'(i_operation);
        in_word.pixel  = i_pixel;
        in_word.kidx   = i_knee_index;
        in_word.kx     = i_knee_x;
        in_word.ky     = i_knee_y;
        in_word.kslope = i_knee_slope;
    end

    pwl_knee_search u_search (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_knee_count (r_knee_count),
        .i_valid      (i_in_valid),
        .o_ready      (o_in_ready),
        .i_word       (in_word),
        .o_valid      (seg_valid),
        .i_ready      (seg_ready),
        .o_seg        (seg)
    );

    pwl_knee_fetch u_fetch (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (seg_valid),
        .o_ready (seg_ready),
        .i_seg   (seg),
        .o_valid (fetch_valid),
        .i_ready (fetch_ready),
        .o_fetch (fetch)
    );

    pwl_seg_eval u_eval (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_max_value   (r_max_value),
        .i_valid       (fetch_valid),
        .o_ready       (fetch_ready),
        .i_fetch       (fetch),
        .o_valid       (o_out_valid),
        .i_ready       (i_out_ready),
        .o_expanded    (o_expanded),
        .o_curve_error (o_curve_error)
    );

endmodule
